@@ design/rect_circle_fill_blitter_defines.svh @@
// assertion macros for the rectangle and circle fill blitter
// no dependencies; expects clk and rst in the scope of each use
`ifndef RECT_CIRCLE_FILL_BLITTER_DEFINES_SVH
`define RECT_CIRCLE_FILL_BLITTER_DEFINES_SVH

`ifndef SYNTHESIS
`define RCFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RCFB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCFB_ASSERT(label, prop, msg)
`define RCFB_ASSERT_RST(label, prop, msg)
`endif

`endif

@@ design/rcfb_pkg.sv @@
// shared types and constants for the rectangle and circle fill blitter
// no dependencies
package rcfb_pkg;

  localparam int SCREEN_W    = 240;
  localparam int SCREEN_H    = 240;
  localparam int FB_DEPTH    = SCREEN_W * SCREEN_H;
  localparam int ADDR_W      = $clog2(FB_DEPTH);
  localparam int COL_W       = $clog2(SCREEN_W);
  localparam int ROW_W       = $clog2(SCREEN_H);
  localparam int POS_W       = 10;
  localparam int SPAN_W      = 9;
  localparam int COLOR_W     = 16;
  localparam int CRD_W       = 12;
  localparam int RR_W        = 2 * SPAN_W;
  localparam int SQ_W        = 20;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_FILL   = 2'd0,
    OP_RECT   = 2'd1,
    OP_CIRCLE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct packed {
    op_t                      op;
    logic                     empty;
    logic [COL_W-1:0]         c0;
    logic [COL_W-1:0]         c1;
    logic [ROW_W-1:0]         r0;
    logic [ROW_W-1:0]         r1;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [RR_W-1:0]          rr;
    logic [COLOR_W-1:0]       color;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } eng_status_t;

  typedef enum logic [2:0] {
    E_CLEAR,
    E_IDLE,
    E_SETUP,
    E_SQ,
    E_RUN,
    E_READ,
    E_DONE
  } eng_state_t;

endpackage

@@ design/rcfb_front.sv @@
// front end: accepts command beats, clips the shape to the screen, builds a queue entry
// depends on rcfb_pkg
module rcfb_front (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic signed [rcfb_pkg::POS_W-1:0] pos_x,
  input  logic signed [rcfb_pkg::POS_W-1:0] pos_y,
  input  logic [rcfb_pkg::SPAN_W-1:0]     span_w,
  input  logic [rcfb_pkg::SPAN_W-1:0]     span_h,
  input  logic [rcfb_pkg::SPAN_W-1:0]     radius,
  input  logic [rcfb_pkg::COLOR_W-1:0]    color,
  input  logic                            q_full,
  input  rcfb_pkg::eng_status_t           status,
  output logic                            q_push,
  output rcfb_pkg::cmd_t                  q_cmd
);
  import rcfb_pkg::*;

  crd_t xs, ys, ws, hs, rs;
  crd_t lo_x, hi_x, lo_y, hi_y;
  crd_t c0s, c1s, r0s, r1s;
  op_t  op_c;

  assign in_ready = !q_full && !status.clearing;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    op_c = op_t'(op);
    xs = crd_t'(pos_x);
    ys = crd_t'(pos_y);
    ws = crd_t'(span_w);
    hs = crd_t'(span_h);
    rs = crd_t'(radius);
    unique case (op_c)
      OP_FILL: begin
        lo_x = '0;
        hi_x = crd_t'(SCREEN_W - 1);
        lo_y = '0;
        hi_y = crd_t'(SCREEN_H - 1);
      end
      OP_RECT: begin
        lo_x = xs;
        hi_x = xs + ws - crd_t'(1);
        lo_y = ys;
        hi_y = ys + hs - crd_t'(1);
      end
      OP_CIRCLE: begin
        lo_x = xs - rs;
        hi_x = xs + rs;
        lo_y = ys - rs;
        hi_y = ys + rs;
      end
      default: begin
        lo_x = xs;
        hi_x = xs;
        lo_y = ys;
        hi_y = ys;
      end
    endcase
    c0s = (lo_x < crd_t'(0)) ? crd_t'(0) : lo_x;
    c1s = (hi_x > crd_t'(SCREEN_W - 1)) ? crd_t'(SCREEN_W - 1) : hi_x;
    r0s = (lo_y < crd_t'(0)) ? crd_t'(0) : lo_y;
    r1s = (hi_y > crd_t'(SCREEN_H - 1)) ? crd_t'(SCREEN_H - 1) : hi_y;

    q_cmd.op    = op_c;
    q_cmd.empty = (c0s > c1s) || (r0s > r1s);
    q_cmd.c0    = c0s[COL_W-1:0];
    q_cmd.c1    = c1s[COL_W-1:0];
    q_cmd.r0    = r0s[ROW_W-1:0];
    q_cmd.r1    = r1s[ROW_W-1:0];
    q_cmd.x     = pos_x;
    q_cmd.y     = pos_y;
    q_cmd.rr    = RR_W'(radius) * RR_W'(radius);
    q_cmd.color = color;
  end

endmodule

@@ design/rcfb_cmd_queue.sv @@
// short command queue between the front end and the drawing engine
// depends on rcfb_pkg
module rcfb_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcfb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output rcfb_pkg::cmd_t pop_cmd
);
  import rcfb_pkg::*;

  localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t            entries [QUEUE_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;

  assign full      = (count == (QA_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QA_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QA_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QA_W+1)'(1);
      end
    end
  end

endmodule

@@ design/rcfb_engine.sv @@
// drawing engine: framebuffer, clearing pass, raster walk, read port, result register
// depends on rcfb_pkg and rect_circle_fill_blitter_defines.svh
module rcfb_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  rcfb_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output rcfb_pkg::eng_status_t        status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rcfb_pkg::COLOR_W-1:0] read_data,
  output logic                         in_bounds
);
  import rcfb_pkg::*;
  `include "rect_circle_fill_blitter_defines.svh"

  localparam logic [ADDR_W-1:0] W_A = ADDR_W'(SCREEN_W);

  eng_state_t           state, state_next;
  cmd_t                 cmd;
  logic [COLOR_W-1:0]   mem [FB_DEPTH];
  logic [COLOR_W-1:0]   rd_q;
  logic [ADDR_W-1:0]    addr;
  logic [ADDR_W-1:0]    row_addr;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  crd_t                 dx0, dx, dy;
  logic [SQ_W-1:0]      sqx0, sqx, sqy;
  logic signed [2*CRD_W-1:0] px, py;
  logic [SQ_W:0]        sq_sum;
  logic                 hit, row_end, last;
  logic                 mem_we, mem_re, res_load;
  logic [COLOR_W-1:0]   mem_wdata;

  assign status.clearing = (state == E_CLEAR);

  assign px        = dx0 * dx0;
  assign py        = dy * dy;
  assign sq_sum    = {1'b0, sqx} + {1'b0, sqy};
  assign hit       = sq_sum <= (SQ_W+1)'(cmd.rr);
  assign row_end   = (col == cmd.c1);
  assign last      = row_end && (row == cmd.r1);
  assign mem_wdata = (state == E_CLEAR) ? '0 : cmd.color;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      E_CLEAR: begin
        mem_we = 1'b1;
        if (addr == ADDR_W'(FB_DEPTH - 1)) begin
          state_next = E_IDLE;
        end
      end
      E_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_cmd.empty ? E_DONE : E_SETUP;
        end
      end
      E_SETUP: state_next = E_SQ;
      E_SQ:    state_next = (cmd.op == OP_READ) ? E_READ : E_RUN;
      E_RUN: begin
        mem_we = (cmd.op != OP_CIRCLE) || hit;
        if (last) begin
          state_next = E_DONE;
        end
      end
      E_READ: begin
        mem_re     = 1'b1;
        state_next = E_DONE;
      end
      E_DONE: begin
        if (!out_valid || out_ready) begin
          res_load   = 1'b1;
          state_next = E_IDLE;
        end
      end
      default: state_next = E_CLEAR;
    endcase
  end

  // framebuffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[addr];
    end
  end

  // raster walk
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      case (state)
        E_CLEAR: begin
          addr <= addr + ADDR_W'(1);
        end
        E_SQ: begin
          addr <= row_addr + ADDR_W'(cmd.c0);
        end
        E_RUN: begin
          if (row_end) begin
            addr <= row_addr + W_A + ADDR_W'(cmd.c0);
          end else begin
            addr <= addr + ADDR_W'(1);
          end
        end
        default: begin
          addr <= addr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_cmd;
    end
    case (state)
      E_SETUP: begin
        row_addr <= ADDR_W'(cmd.r0) * W_A;
        dx0      <= crd_t'(cmd.c0) - crd_t'(cmd.x);
        dy       <= crd_t'(cmd.r0) - crd_t'(cmd.y);
      end
      E_SQ: begin
        sqx0 <= px[SQ_W-1:0];
        sqx  <= px[SQ_W-1:0];
        sqy  <= py[SQ_W-1:0];
        dx   <= dx0;
        col  <= cmd.c0;
        row  <= cmd.r0;
      end
      E_RUN: begin
        if (row_end) begin
          row      <= row + ROW_W'(1);
          row_addr <= row_addr + W_A;
          col      <= cmd.c0;
          dx       <= dx0;
          sqx      <= sqx0;
          dy       <= dy + crd_t'(1);
          sqy      <= sqy + {{(SQ_W-CRD_W-1){dy[CRD_W-1]}}, dy, 1'b1};
        end else begin
          col <= col + COL_W'(1);
          dx  <= dx + crd_t'(1);
          sqx <= sqx + {{(SQ_W-CRD_W-1){dx[CRD_W-1]}}, dx, 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      if ((cmd.op == OP_READ) && !cmd.empty) begin
        read_data <= rd_q;
        in_bounds <= 1'b1;
      end else begin
        read_data <= '0;
        in_bounds <= 1'b0;
      end
    end
  end

  `RCFB_ASSERT(a_no_result_in_clear, (state == E_CLEAR) |-> !out_valid, "result during clear")
  `RCFB_ASSERT(a_wr_addr_range, mem_we |-> (addr < ADDR_W'(FB_DEPTH)), "write beyond framebuffer")
  `RCFB_ASSERT(a_box_col, state == E_RUN |-> col >= cmd.c0 && col <= cmd.c1, "column out of box")
  `RCFB_ASSERT(a_box_row, state == E_RUN |-> row <= cmd.r1, "row out of box")
  `RCFB_ASSERT(a_sq_track, state == E_RUN |-> int'(sqx) == int'(dx) * int'(dx), "sq out of step")
  `RCFB_ASSERT(a_load_from_done, res_load |-> state == E_DONE, "result loaded outside done")

endmodule

@@ design/rect_circle_fill_blitter.sv @@
// top level of the rectangle and circle fill blitter
// depends on rcfb_pkg, rcfb_front, rcfb_cmd_queue, rcfb_engine
//
// channel   direction  handshake            beat
// command   in         in_valid/in_ready    op, pos_x, pos_y, span_w, span_h, radius, color
// result    out        out_valid/out_ready  read_data, in_bounds
//
// after reset a clearing pass writes black over all 57600 pixels, one per cycle,
// and no command beat is taken until it ends
// a drawing command walks its clipped bounding box one pixel at a time through
// the single write port of the framebuffer; a full fill walks every pixel
// commands pass setup, squaring, walk or read, done; empty or off-screen ones skip to done
// two commands queue ahead of the engine; a waiting result stalls the engine, then the input
module rect_circle_fill_blitter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        op,
  input  logic signed [rcfb_pkg::POS_W-1:0] pos_x,
  input  logic signed [rcfb_pkg::POS_W-1:0] pos_y,
  input  logic [rcfb_pkg::SPAN_W-1:0]       span_w,
  input  logic [rcfb_pkg::SPAN_W-1:0]       span_h,
  input  logic [rcfb_pkg::SPAN_W-1:0]       radius,
  input  logic [rcfb_pkg::COLOR_W-1:0]      color,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rcfb_pkg::COLOR_W-1:0]      read_data,
  output logic                              in_bounds
);
  import rcfb_pkg::*;

  cmd_t        push_cmd, pop_cmd;
  logic        q_push, q_full, q_pop, q_valid;
  eng_status_t status;

  rcfb_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .span_w   (span_w),
    .span_h   (span_h),
    .radius   (radius),
    .color    (color),
    .q_full   (q_full),
    .status   (status),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  rcfb_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  rcfb_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .in_bounds (in_bounds)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for rect_circle_fill_blitter: a shadow framebuffer
// predicts every reply while random idling and a long receiver hold-off run
// depends on rcfb_pkg and the rect_circle_fill_blitter rtl
module testbench;
  import rcfb_pkg::*;

  typedef struct packed {
    op_t                      op;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [SPAN_W-1:0]        w;
    logic [SPAN_W-1:0]        h;
    logic [SPAN_W-1:0]        r;
    logic [COLOR_W-1:0]       c;
  } blit_cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] data;
    logic               inb;
  } blit_reply_t;

  class frame_mirror;
    logic [COLOR_W-1:0] pixels [FB_DEPTH];
    blit_reply_t        replies_due [$];
    int                 errors;
    longint             work_budget;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      errors = 0;
      work_budget = 0;
    endfunction

    function void take_command(blit_cmd_t cmd);
      int x, y, w, h, r, rr, c0, c1, r0, r1, row, col;
      blit_reply_t reply;
      x = int'(cmd.x);
      y = int'(cmd.y);
      w = int'(cmd.w);
      h = int'(cmd.h);
      r = int'(cmd.r);
      reply = '0;
      work_budget += 64;
      case (cmd.op)
        OP_FILL: begin
          foreach (pixels[i]) pixels[i] = cmd.c;
          work_budget += FB_DEPTH;
        end
        OP_RECT: begin
          c0 = (x > 0) ? x : 0;
          c1 = (x + w < SCREEN_W) ? x + w : SCREEN_W;
          r0 = (y > 0) ? y : 0;
          r1 = (y + h < SCREEN_H) ? y + h : SCREEN_H;
          for (row = r0; row < r1; row++) begin
            for (col = c0; col < c1; col++) pixels[row * SCREEN_W + col] = cmd.c;
          end
          if (c1 > c0 && r1 > r0) work_budget += (c1 - c0) * (r1 - r0);
        end
        OP_CIRCLE: begin
          rr = r * r;
          c0 = (x - r > 0) ? x - r : 0;
          c1 = (x + r < SCREEN_W - 1) ? x + r : SCREEN_W - 1;
          r0 = (y - r > 0) ? y - r : 0;
          r1 = (y + r < SCREEN_H - 1) ? y + r : SCREEN_H - 1;
          for (row = r0; row <= r1; row++) begin
            for (col = c0; col <= c1; col++) begin
              if ((col - x) * (col - x) + (row - y) * (row - y) <= rr)
                pixels[row * SCREEN_W + col] = cmd.c;
            end
          end
          if (c1 >= c0 && r1 >= r0) work_budget += (c1 - c0 + 1) * (r1 - r0 + 1);
        end
        default: begin
          if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H) begin
            reply.data = pixels[y * SCREEN_W + x];
            reply.inb  = 1'b1;
          end
        end
      endcase
      replies_due.push_back(reply);
    endfunction

    function void check_reply(logic [COLOR_W-1:0] data, logic inb);
      blit_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual read_data %h in_bounds %b",
                 $time, data, inb);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (data !== want.data) begin
        $display("%0t: read_data mismatch: expected %h, actual %h", $time, want.data, data);
        errors++;
      end
      if (inb !== want.inb) begin
        $display("%0t: in_bounds mismatch: expected %b, actual %b", $time, want.inb, inb);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               op;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [SPAN_W-1:0]        span_w;
  logic [SPAN_W-1:0]        span_h;
  logic [SPAN_W-1:0]        radius;
  logic [COLOR_W-1:0]       color;
  logic                     out_valid;
  logic                     out_ready;
  logic [COLOR_W-1:0]       read_data;
  logic                     in_bounds;

  frame_mirror mirror = new();
  bit          source_idling = 1'b1;
  bit          sink_idling = 1'b1;
  int          hold_requests = 0;
  longint      cycle_count = 0;

  rect_circle_fill_blitter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .span_w    (span_w),
    .span_h    (span_h),
    .radius    (radius),
    .color     (color),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .in_bounds (in_bounds)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic blit_cmd_t blit(op_t o, int x, int y, int w, int h, int r, int c);
    blit_cmd_t cmd;
    cmd.op = o;
    cmd.x  = POS_W'(x);
    cmd.y  = POS_W'(y);
    cmd.w  = SPAN_W'(w);
    cmd.h  = SPAN_W'(h);
    cmd.r  = SPAN_W'(r);
    cmd.c  = COLOR_W'(c);
    return cmd;
  endfunction

  // mostly small shapes and reads near the screen, one in ten with every field wild
  function automatic blit_cmd_t random_command();
    blit_cmd_t cmd;
    int        pick;
    bit        wild;
    pick  = $urandom_range(0, 99);
    wild  = ($urandom_range(0, 9) == 0);
    cmd.x = POS_W'($urandom);
    cmd.y = POS_W'($urandom);
    cmd.w = SPAN_W'($urandom);
    cmd.h = SPAN_W'($urandom);
    cmd.r = SPAN_W'($urandom);
    cmd.c = COLOR_W'($urandom);
    if (pick < 2) begin
      cmd.op = OP_FILL;
    end else if (pick < 34) begin
      cmd.op = OP_RECT;
      if (!wild) begin
        cmd.x = POS_W'($urandom_range(0, 279) - 30);
        cmd.y = POS_W'($urandom_range(0, 279) - 30);
        cmd.w = SPAN_W'($urandom_range(0, 24));
        cmd.h = SPAN_W'($urandom_range(0, 24));
      end
    end else if (pick < 60) begin
      cmd.op = OP_CIRCLE;
      if (!wild) begin
        cmd.x = POS_W'($urandom_range(0, 279) - 20);
        cmd.y = POS_W'($urandom_range(0, 279) - 20);
        cmd.r = SPAN_W'($urandom_range(0, 20));
      end
    end else begin
      cmd.op = OP_READ;
      if (!wild) begin
        cmd.x = POS_W'($urandom_range(0, 249) - 5);
        cmd.y = POS_W'($urandom_range(0, 249) - 5);
      end
    end
    return cmd;
  endfunction

  task automatic send_command(input blit_cmd_t cmd);
    while (source_idling && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= cmd.op;
    pos_x    <= cmd.x;
    pos_y    <= cmd.y;
    span_w   <= cmd.w;
    span_h   <= cmd.h;
    radius   <= cmd.r;
    color    <= cmd.c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.take_command(cmd);
    @(negedge clk);
  endtask

  // result side: random stalls plus one long hold-off
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests > holds_served) begin
        holds_served++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(sink_idling && $urandom_range(0, 99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) mirror.check_reply(read_data, in_bounds);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 200000 + 4 * mirror.work_budget) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    blit_cmd_t cmd;
    rst      = 1'b1;
    in_valid = 1'b0;
    op       = OP_FILL;
    pos_x    = '0;
    pos_y    = '0;
    span_w   = '0;
    span_h   = '0;
    radius   = '0;
    color    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_command(blit(OP_READ, 0, 0, 0, 0, 0, 16'h0000));
    send_command(blit(OP_READ, 239, 239, 511, 511, 511, 16'hFFFF));
    send_command(blit(OP_READ, -1, 0, 0, 0, 0, 0));
    send_command(blit(OP_READ, 0, 240, 0, 0, 0, 0));
    send_command(blit(OP_RECT, 10, 20, 5, 3, 0, 16'h1234));
    send_command(blit(OP_READ, 14, 22, 0, 0, 0, 0));
    send_command(blit(OP_READ, 15, 22, 0, 0, 0, 0));
    send_command(blit(OP_RECT, 0, 0, 0, 10, 0, 16'hFFFF));
    send_command(blit(OP_RECT, 0, 0, 10, 0, 0, 16'hFFFF));
    send_command(blit(OP_READ, 0, 0, 0, 0, 0, 0));
    send_command(blit(OP_RECT, -5, -5, 10, 10, 0, 16'hA5A5));
    send_command(blit(OP_RECT, 235, 235, 511, 511, 0, 16'h5A5A));
    send_command(blit(OP_RECT, -512, -512, 511, 511, 0, 16'hFFFF));
    send_command(blit(OP_CIRCLE, 100, 100, 0, 0, 0, 16'h0F0F));
    send_command(blit(OP_READ, 100, 100, 0, 0, 0, 0));
    send_command(blit(OP_CIRCLE, -1, 5, 0, 0, 0, 16'hFFFF));
    send_command(blit(OP_CIRCLE, 239, 0, 0, 0, 10, 16'hF00F));
    send_command(blit(OP_CIRCLE, -512, -512, 0, 0, 511, 16'hFFFF));
    send_command(blit(OP_CIRCLE, -200, 100, 0, 0, 260, 16'h7BEF));
    send_command(blit(OP_READ, 59, 100, 0, 0, 0, 0));
    send_command(blit(OP_READ, 511, -512, 0, 0, 0, 0));
    send_command(blit(OP_FILL, -512, 511, 511, 511, 511, 16'hFFFF));
    send_command(blit(OP_READ, 120, 120, 0, 0, 0, 0));
    send_command(blit(OP_READ, -512, 511, 0, 0, 0, 0));

    source_idling = 1'b0;
    sink_idling = 1'b0;
    for (n = 0; n < 50; n++) send_command(random_command());

    // drain so the hold-off below backs up into the input
    in_valid <= 1'b0;
    while (mirror.replies_due.size() != 0) @(posedge clk);
    @(negedge clk);
    source_idling = 1'b1;
    sink_idling = 1'b1;
    hold_requests++;
    for (n = 0; n < 12; n++) begin
      cmd = random_command();
      cmd.op = OP_READ;
      send_command(cmd);
    end
    for (n = 0; n < 74; n++) send_command(random_command());
    in_valid <= 1'b0;

    while (mirror.replies_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mirror.errors == 0 && mirror.replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/rcfb_pkg.sv
design/rcfb_front.sv
design/rcfb_cmd_queue.sv
design/rcfb_engine.sv
design/rect_circle_fill_blitter.sv
sim/testbench.sv
